### src/lse_pkg.sv
// shared types and constants for the sequential list engine
// no dependencies; compiled first
`default_nettype none

package lse_pkg;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } lse_state_t;

  // command broadcast to every cell while the wave travels
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              ok;
    logic [DATA_W-1:0] val;
  } lse_ctl_t;

endpackage

`default_nettype wire

### src/lse_in_if.sv
// command channel of the list engine: valid/ready plus command payload
// depends on lse_pkg
`default_nettype none

interface lse_in_if
  import lse_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] value_in;

  modport source (output valid, command, position, value_in, input ready);
  modport sink   (input valid, command, position, value_in, output ready);
endinterface

`default_nettype wire

### src/lse_out_if.sv
// result channel of the list engine: valid/ready plus result payload
// depends on lse_pkg
`default_nettype none

interface lse_out_if
  import lse_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [DATA_W-1:0] value_out;
  logic [POS_W-1:0]  found_position;
  logic [POS_W-1:0]  length_now;
  logic              is_empty;

  modport source (output valid, ok, value_out, found_position, length_now, is_empty,
                  input ready);
  modport sink   (input valid, ok, value_out, found_position, length_now, is_empty,
                  output ready);
endinterface

`default_nettype wire

### src/lse_cell.sv
// one list cell: holds one element and passes the command wave to the next cell
// depends on lse_pkg
`default_nettype none

module lse_cell
  import lse_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 8,
  parameter int LW  = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lse_ctl_t          ctl,
  input  wire logic [CW-1:0]     pos0,
  input  wire logic [CW-1:0]     len,
  input  wire logic              act_in,
  input  wire logic [DATA_W-1:0] carry_in,
  input  wire logic              hit_in,
  input  wire logic [LW-1:0]     fidx_in,
  input  wire logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0]      data_out,
  output logic                   act_out,
  output logic [DATA_W-1:0]      carry_out,
  output logic                   hit_out,
  output logic [LW-1:0]          fidx_out
);

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX1_C = CW'(IDX + 1);
  localparam logic [LW-1:0] POS_C  = LW'(IDX + 1);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              act_r;
  logic [DATA_W-1:0] carry_r, carry_nxt;
  logic              hit_r, hit_nxt;
  logic [LW-1:0]     fidx_r, fidx_nxt;

  always_comb begin
    data_nxt  = data_r;
    carry_nxt = carry_in;
    hit_nxt   = hit_in;
    fidx_nxt  = fidx_in;
    if (act_in && ctl.ok) begin
      case (ctl.cmd)
        CMD_INSERT: begin
          // the displaced element rides the wave into the next cell
          if (IDX_C == pos0) begin
            carry_nxt = data_r;
            data_nxt  = ctl.val;
          end else if (IDX_C > pos0 && IDX_C <= len) begin
            carry_nxt = data_r;
            data_nxt  = carry_in;
          end
        end
        CMD_DELETE: begin
          if (IDX_C == pos0) begin
            carry_nxt = data_r;
          end
          // right neighbor is not yet touched by the wave
          if (IDX_C >= pos0 && IDX1_C < len) begin
            data_nxt = right_data;
          end
        end
        CMD_GET: begin
          if (IDX_C == pos0) begin
            carry_nxt = data_r;
          end
        end
        CMD_LOCATE: begin
          if (!hit_in && IDX_C < len && data_r == ctl.val) begin
            hit_nxt  = 1'b1;
            fidx_nxt = POS_C;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    carry_r <= carry_nxt;
    hit_r   <= hit_nxt;
    fidx_r  <= fidx_nxt;
  end

  assign data_out  = data_r;
  assign act_out   = act_r;
  assign carry_out = carry_r;
  assign hit_out   = hit_r;
  assign fidx_out  = fidx_r;

endmodule

`default_nettype wire

### src/sequential_list_engine_core.sv
// top level of the list engine: command control, length count and the cell row
// depends on lse_pkg, lse_in_if, lse_out_if and lse_cell
//
// channel  | dir | handshake     | payload
// in_if    | in  | valid / ready | command, position, value_in
// out_if   | out | valid / ready | ok, value_out, found_position, length_now, is_empty
//
// result valid rises once the wave of an accepted command has left the row: a wave
// walks the cell row one cell per cycle, shifting, reading or comparing as it passes
// a new command is taken only after the result of the last one has been handed off
// in_if.ready is high only while no command is in flight; a result waiting on
// out_if does not block acceptance, only the hand-off of the next result
// synchronous active-low reset empties the list; element contents are not cleared
`default_nettype none

module sequential_list_engine_core
  import lse_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lse_in_if.sink     in_if,
  lse_out_if.source  out_if
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  lse_state_t st_r, st_nxt;

  logic [LW-1:0]     len_r;
  lse_ctl_t          ctl_r;
  logic [CW-1:0]     pos0_r;
  logic              launch_r;

  logic              res_ok_r;
  logic [DATA_W-1:0] res_vout_r;
  logic [LW-1:0]     res_fidx_r;

  logic              out_valid_r;
  logic              out_ok_r;
  logic [DATA_W-1:0] out_vout_r;
  logic [POS_W-1:0]  out_fidx_r;
  logic [POS_W-1:0]  out_len_r;
  logic              out_empty_r;

  logic              in_ready;
  logic              accept;
  logic              cmd_ok;
  logic [CW-1:0]     pos_w;
  logic [CW-1:0]     len_w;
  logic              wave_end;
  logic              hand_off;
  logic [LW-1:0]     len_nxt;

  // wave links: element k feeds cell k, element CAPACITY leaves the row
  logic [CAPACITY:0]             act_w;
  logic [DATA_W-1:0]             carry_w [CAPACITY+1];
  logic [CAPACITY:0]             hit_w;
  logic [LW-1:0]                 fidx_w  [CAPACITY+1];
  logic [DATA_W-1:0]             data_w  [CAPACITY+1];

  assign pos_w    = CW'(in_if.position);
  assign len_w    = CW'(len_r);
  assign accept   = in_if.valid && in_ready;
  assign wave_end = act_w[CAPACITY];
  assign hand_off = (st_r == ST_DONE) && (!out_valid_r || out_if.ready);

  always_comb begin
    case (in_if.command)
      CMD_INSERT: cmd_ok = (pos_w != '0) && (pos_w <= len_w + CW'(1)) && (len_w < CAP_C);
      CMD_DELETE: cmd_ok = (pos_w != '0) && (pos_w <= len_w);
      CMD_GET:    cmd_ok = (pos_w != '0) && (pos_w <= len_w);
      CMD_LOCATE: cmd_ok = 1'b1;
      CMD_CLEAR:  cmd_ok = 1'b1;
      default:    cmd_ok = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_RUN;
      ST_RUN:  if (wave_end) st_nxt = ST_DONE;
      ST_DONE: if (hand_off) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    case (st_r)
      ST_IDLE: in_ready = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_if.ready = in_ready;

  always_comb begin
    len_nxt = len_r;
    if (ctl_r.ok) begin
      case (ctl_r.cmd)
        CMD_INSERT: len_nxt = len_r + LW'(1);
        CMD_DELETE: len_nxt = len_r - LW'(1);
        CMD_CLEAR:  len_nxt = '0;
        default:    len_nxt = len_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      len_r       <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      launch_r <= accept;
      if (wave_end) begin
        len_r <= len_nxt;
      end
      if (hand_off) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r.cmd <= in_if.command;
      ctl_r.ok  <= cmd_ok;
      ctl_r.val <= in_if.value_in;
      pos0_r    <= pos_w - CW'(1);
    end
    if (wave_end) begin
      res_ok_r   <= ctl_r.ok;
      res_vout_r <= (ctl_r.cmd == CMD_DELETE || ctl_r.cmd == CMD_GET)
                    ? carry_w[CAPACITY] : '0;
      res_fidx_r <= (ctl_r.cmd == CMD_LOCATE) ? fidx_w[CAPACITY] : '0;
    end
    if (hand_off) begin
      out_ok_r    <= res_ok_r;
      out_vout_r  <= res_vout_r;
      out_fidx_r  <= POS_W'(res_fidx_r);
      out_len_r   <= POS_W'(len_r);
      out_empty_r <= (len_r == '0);
    end
  end

  assign act_w[0]           = launch_r;
  assign carry_w[0]         = '0;
  assign hit_w[0]           = 1'b0;
  assign fidx_w[0]          = '0;
  assign data_w[CAPACITY]   = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    lse_cell #(
      .IDX (k),
      .CW  (CW),
      .LW  (LW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl_r),
      .pos0       (pos0_r),
      .len        (len_w),
      .act_in     (act_w[k]),
      .carry_in   (carry_w[k]),
      .hit_in     (hit_w[k]),
      .fidx_in    (fidx_w[k]),
      .right_data (data_w[k+1]),
      .data_out   (data_w[k]),
      .act_out    (act_w[k+1]),
      .carry_out  (carry_w[k+1]),
      .hit_out    (hit_w[k+1]),
      .fidx_out   (fidx_w[k+1])
    );
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.ok             = out_ok_r;
  assign out_if.value_out      = out_vout_r;
  assign out_if.found_position = out_fidx_r;
  assign out_if.length_now     = out_len_r;
  assign out_if.is_empty       = out_empty_r;

endmodule

`default_nettype wire
